FILE: hdl/nmeacs_pkg.sv
// Shared types and constants for the NMEA checksum / field extractor.
// No dependencies; imported by every module of the block.
package nmeacs_pkg;

	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;

	localparam int unsigned MaxFieldLen = 199;
	localparam logic [7:0]  MAX_FIELD_LEN = 8'(MaxFieldLen);

	localparam logic [4:0] COMMA_SAT = 5'd31;
	localparam logic [4:0] FIELD_INDEX_RST = 5'd1;

	localparam logic KIND_FIELD   = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam int unsigned ResDepth = 4;
	localparam int unsigned ResPtrW  = $clog2(ResDepth);
	localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

	typedef struct packed {
		logic       kind;
		logic [7:0] field_char;
		logic       checksum_ok;
		logic       field_present;
		logic       final_flag;
	} res_t;

	// Results produced by one accepted byte: cnt of them, first in res0.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       res0;
		res_t       res1;
	} res_push_t;

	// Uppercase hex character of one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h37 + {4'd0, nib};
		end
		return c;
	endfunction

endpackage

FILE: hdl/nmeacs_parse.sv
// Per-sentence state: running checksum, star/digit check, comma count and
// field selection. Depends on nmeacs_pkg.
module nmeacs_parse import nmeacs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] sentence_byte,
	input  logic       end_of_sentence,
	input  logic [4:0] field_index,
	output res_push_t  push
);

	logic       first_q;
	logic [7:0] xor_q;
	logic       star_q;
	logic [1:0] digits_q;
	logic       match_q;
	logic [4:0] comma_q;
	logic [7:0] len_q;
	logic       ovf_q;

	logic       star_d;
	logic [7:0] xor_d;
	logic [1:0] digits_d;
	logic       match_d;
	logic [4:0] comma_d;
	logic [7:0] len_d;
	logic       ovf_d;
	logic       emit;
	logic [3:0] nib;
	res_t       fld;
	res_t       vrd;

	always_comb begin
		star_d   = star_q;
		xor_d    = xor_q;
		digits_d = digits_q;
		match_d  = match_q;
		comma_d  = comma_q;
		ovf_d    = ovf_q;
		len_d    = len_q;
		emit     = 1'b0;
		nib      = (digits_q == 2'd0) ? xor_q[7:4] : xor_q[3:0];

		if (!first_q) begin
			if (!star_q) begin
				if (sentence_byte == CHAR_STAR) begin
					star_d = 1'b1;
				end else begin
					xor_d = xor_q ^ sentence_byte;
				end
			end else if (digits_q < 2'd2) begin
				if (sentence_byte != hex_char(nib)) begin
					match_d = 1'b0;
				end
				digits_d = digits_q + 2'd1;
			end
		end

		if (sentence_byte == CHAR_COMMA) begin
			if (comma_q < COMMA_SAT) begin
				comma_d = comma_q + 5'd1;
			end else begin
				ovf_d = 1'b1;
			end
		end else if (!ovf_q && comma_q == field_index && len_q < MAX_FIELD_LEN) begin
			len_d = len_q + 8'd1;
			emit  = 1'b1;
		end

		fld.kind          = KIND_FIELD;
		fld.field_char    = sentence_byte;
		fld.checksum_ok   = 1'b0;
		fld.field_present = 1'b0;
		fld.final_flag    = 1'b0;

		vrd.kind          = KIND_VERDICT;
		vrd.field_char    = 8'd0;
		vrd.checksum_ok   = star_d && digits_d == 2'd2 && match_d;
		vrd.field_present = ovf_d || comma_d >= field_index;
		vrd.final_flag    = 1'b1;

		push.res0 = emit ? fld : vrd;
		push.res1 = vrd;
		if (!accept) begin
			push.cnt = 2'd0;
		end else begin
			push.cnt = {1'b0, emit} + {1'b0, end_of_sentence};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= 1'b1;
			xor_q    <= 8'd0;
			star_q   <= 1'b0;
			digits_q <= 2'd0;
			match_q  <= 1'b1;
			comma_q  <= 5'd0;
			len_q    <= 8'd0;
			ovf_q    <= 1'b0;
		end else if (accept) begin
			if (end_of_sentence) begin
				first_q  <= 1'b1;
				xor_q    <= 8'd0;
				star_q   <= 1'b0;
				digits_q <= 2'd0;
				match_q  <= 1'b1;
				comma_q  <= 5'd0;
				len_q    <= 8'd0;
				ovf_q    <= 1'b0;
			end else begin
				first_q  <= 1'b0;
				xor_q    <= xor_d;
				star_q   <= star_d;
				digits_q <= digits_d;
				match_q  <= match_d;
				comma_q  <= comma_d;
				len_q    <= len_d;
				ovf_q    <= ovf_d;
			end
		end
	end

endmodule

FILE: hdl/nmeacs_resq.sv
// Small result queue: takes up to two results per cycle, hands out one beat
// per cycle while stall is low. Depends on nmeacs_pkg.
module nmeacs_resq import nmeacs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  res_push_t push,
	output logic      room,
	output logic      valid,
	input  logic      stall,
	output res_t      head
);

	res_t               mem [ResDepth];
	logic [ResPtrW-1:0] wr_q;
	logic [ResPtrW-1:0] rd_q;
	logic [ResCntW-1:0] cnt_q;
	logic               pop;

	assign valid = cnt_q != '0;
	assign pop   = valid && !stall;
	assign head  = mem[rd_q];
	// two free slots needed so that a byte with its verdict always fits
	assign room  = cnt_q <= ResCntW'(ResDepth - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.res0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_q + ResPtrW'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + ResPtrW'(push.cnt);
			if (pop) begin
				rd_q <= rd_q + ResPtrW'(1);
			end
			cnt_q <= cnt_q + ResCntW'(push.cnt) - ResCntW'(pop);
		end
	end

endmodule

FILE: hdl/nmea_checksum_field_extractor.sv
// Top level of the NMEA checksum checker and field extractor.
// Depends on nmeacs_pkg, nmeacs_parse, nmeacs_resq.
//
//   channel    handshake                  payload
//   sentence   sentence_valid/_stall in   sentence_byte, end_of_sentence
//   result     result_valid/_stall out    kind, field_char, checksum_ok,
//                                         field_present, final_flag
//   config     cfg_we in                  cfg_wdata (field_index)
//
// One byte per cycle while sentence_stall is low; a byte's results are written
// to a 4-entry queue at the accepting edge and leave it in order on the result side.
// sentence_stall rises only when fewer than two queue slots are free, so the
// input keeps moving while a result beat waits on result_stall.
// Reset clears the sentence state and the queue; field_index resets to 1.
module nmea_checksum_field_extractor import nmeacs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	input  logic       sentence_valid,
	output logic       sentence_stall,
	input  logic [7:0] sentence_byte,
	input  logic       end_of_sentence,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       kind,
	output logic [7:0] field_char,
	output logic       checksum_ok,
	output logic       field_present,
	output logic       final_flag
);

	logic [4:0] field_index_q;
	logic       accept;
	logic       room;
	res_push_t  push;
	res_t       head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_index_q <= FIELD_INDEX_RST;
		end else if (cfg_we) begin
			field_index_q <= cfg_wdata;
		end
	end

	assign sentence_stall = !room;
	assign accept         = sentence_valid && room;

	nmeacs_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.sentence_byte   (sentence_byte),
		.end_of_sentence (end_of_sentence),
		.field_index     (field_index_q),
		.push            (push)
	);

	nmeacs_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (result_valid),
		.stall  (result_stall),
		.head   (head)
	);

	assign kind          = head.kind;
	assign field_char    = head.field_char;
	assign checksum_ok   = head.checksum_ok;
	assign field_present = head.field_present;
	assign final_flag    = head.final_flag;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for nmea_checksum_field_extractor: sends sentences one byte per beat,
// predicts field bytes and verdicts in step, and checks every result beat in order.
// Depends on nmeacs_pkg and the RTL of the block only.
module tb;
	import nmeacs_pkg::*;

	localparam int RandBytes  = 1200;
	localparam int PhaseBytes = 150;
	localparam int HoldCycles = 400;
	localparam int SettleCyc  = 4;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [4:0] cfg_wdata = '0;
	logic       sentence_valid = 1'b0;
	logic       sentence_stall;
	logic [7:0] sentence_byte = '0;
	logic       end_of_sentence = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic       kind;
	logic [7:0] field_char;
	logic       checksum_ok;
	logic       field_present;
	logic       final_flag;

	nmea_checksum_field_extractor dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.sentence_valid  (sentence_valid),
		.sentence_stall  (sentence_stall),
		.sentence_byte   (sentence_byte),
		.end_of_sentence (end_of_sentence),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.kind            (kind),
		.field_char      (field_char),
		.checksum_ok     (checksum_ok),
		.field_present   (field_present),
		.final_flag      (final_flag)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// parser shadow state
	logic [4:0] want_field = FIELD_INDEX_RST;
	logic       at_first   = 1'b1;
	logic [7:0] xor_acc    = '0;
	logic       star_hit   = 1'b0;
	logic [1:0] hex_seen   = '0;
	logic       hex_good   = 1'b1;
	logic [4:0] commas     = '0;
	logic [7:0] field_bytes = '0;
	logic       comma_over = 1'b0;

	res_t pending_results[$];
	int   mismatches = 0;

	// sender / receiver knobs
	int gap_max = 0;
	int stall_pct = 0;
	int burst_left = 0;
	int beats_sent = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int run_left = 0;
	logic run_stall = 1'b0;

	logic [7:0] sent_buf[$];

	function automatic logic [7:0] hex_ascii(input logic [3:0] n);
		string digits = "0123456789ABCDEF";
		return digits[n];
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic eos);
		res_t r;
		logic [3:0] nib;
		if (!at_first) begin
			if (!star_hit) begin
				if (b == CHAR_STAR)
					star_hit = 1'b1;
				else
					xor_acc ^= b;
			end else if (hex_seen < 2'd2) begin
				nib = (hex_seen == 2'd0) ? xor_acc[7:4] : xor_acc[3:0];
				if (b != hex_ascii(nib))
					hex_good = 1'b0;
				hex_seen++;
			end
		end
		at_first = 1'b0;

		if (b == CHAR_COMMA) begin
			if (commas != COMMA_SAT)
				commas++;
			else
				comma_over = 1'b1;
		end else if (!comma_over && commas == want_field && field_bytes < MAX_FIELD_LEN) begin
			field_bytes++;
			r = '0;
			r.kind = KIND_FIELD;
			r.field_char = b;
			pending_results.push_back(r);
		end

		if (eos) begin
			r = '0;
			r.kind = KIND_VERDICT;
			r.checksum_ok = star_hit && hex_seen == 2'd2 && hex_good;
			r.field_present = comma_over || commas >= want_field;
			r.final_flag = 1'b1;
			pending_results.push_back(r);
			at_first = 1'b1;
			xor_acc = '0;
			star_hit = 1'b0;
			hex_seen = '0;
			hex_good = 1'b1;
			commas = '0;
			field_bytes = '0;
			comma_over = 1'b0;
		end
	endfunction

	// input side: predict on every accepted beat, track register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (sentence_valid && !sentence_stall)
				parse_byte(sentence_byte, end_of_sentence);
			if (cfg_we)
				want_field = cfg_wdata;
		end
	end

	always @(posedge clk) begin : check_result
		res_t want, got;
		if (arst_n && result_valid && !result_stall) begin
			got = '{kind, field_char, checksum_ok, field_present, final_flag};
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: exp none got k=%0b c=%h ok=%0b p=%0b f=%0b",
					$time, got.kind, got.field_char, got.checksum_ok,
					got.field_present, got.final_flag);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					$display(
"%0t: exp k=%0b c=%h ok=%0b p=%0b f=%0b got k=%0b c=%h ok=%0b p=%0b f=%0b",
						$time, want.kind, want.field_char, want.checksum_ok,
						want.field_present, want.final_flag, got.kind,
						got.field_char, got.checksum_ok, got.field_present,
						got.final_flag);
				end
			end
		end
	end

	// receiver: random stall runs, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack = hold_req;
			hold_left = HoldCycles;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			if (run_left == 0) begin
				run_left = $urandom_range(8, 1);
				run_stall = ($urandom_range(99, 0) < stall_pct);
			end
			run_left--;
			result_stall <= run_stall;
		end
	end

	// called at a rising edge; returns at the edge that took the beat
	task automatic send_beat(input logic [7:0] b, input logic eos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
			if (gap != 0) begin
				sentence_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sentence_valid <= 1'b1;
		sentence_byte <= b;
		end_of_sentence <= eos;
		@(posedge clk);
		while (sentence_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_from(input int first);
		for (int i = first; i < sent_buf.size(); i++)
			send_beat(sent_buf[i], i == sent_buf.size() - 1);
		sent_buf.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			sent_buf.push_back(s[i]);
	endtask

	// XOR of everything after the first byte, then '*' and two hex digits
	task automatic add_checksum();
		logic [7:0] x;
		x = '0;
		for (int i = 1; i < sent_buf.size(); i++)
			x ^= sent_buf[i];
		sent_buf.push_back(CHAR_STAR);
		sent_buf.push_back(hex_ascii(x[7:4]));
		sent_buf.push_back(hex_ascii(x[3:0]));
	endtask

	task automatic wait_idle();
		sentence_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SettleCyc) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [4:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// field index still at its reset value
	task automatic test_reset_field();
		gap_max = 2;
		stall_pct = 30;
		add_text("$");
		send_from(0);
		add_text("$GP,7F");
		add_checksum();
		send_from(0);
		wait_idle();
	endtask

	task automatic test_checksum_cases();
		// leading star is neither the checksum star nor XORed
		add_text("*A");
		add_checksum();
		send_from(0);
		add_text("$A,B");
		send_from(0);
		add_text("$AB*ZZ");
		send_from(0);
		add_text("$J*4a");
		send_from(0);
		add_text("$AB*4");
		send_from(0);
		// trailing text after the digits still counts for the field
		add_text("$X,Y");
		add_checksum();
		add_text(",T,");
		send_from(0);
		add_text("$,");
		sent_buf.push_back(8'h00);
		sent_buf.push_back(8'hFF);
		sent_buf.push_back(8'h80);
		add_checksum();
		send_from(0);
		wait_idle();
	endtask

	task automatic test_field_select();
		cfg_write(5'd0);
		add_text("$GPRMC,1");
		add_checksum();
		send_from(0);
		// register changes partway through a sentence
		add_text("$AB,CD,EF");
		add_checksum();
		for (int i = 0; i < 4; i++)
			send_beat(sent_buf[i], 1'b0);
		wait_idle();
		cfg_write(5'd2);
		send_from(4);
		wait_idle();
	endtask

	task automatic test_comma_saturation();
		cfg_write(5'd31);
		add_text("$");
		repeat (31) sent_buf.push_back(CHAR_COMMA);
		add_text("AB,CD,XY");
		add_checksum();
		send_from(0);
		wait_idle();
		cfg_write(5'd30);
		add_text("$,,,,,Q");
		add_checksum();
		send_from(0);
		wait_idle();
	endtask

	task automatic test_long_field();
		logic [7:0] b;
		cfg_write(5'd1);
		add_text("$L,");
		repeat (210) begin
			do b = 8'($urandom_range(255, 0)); while (b == CHAR_COMMA);
			sent_buf.push_back(b);
		end
		send_from(0);
		wait_idle();
	endtask

	task automatic test_random();
		int start, phase_start, phase, r, n;
		logic [7:0] b;
		start = beats_sent;
		phase = 0;
		while (beats_sent - start < RandBytes) begin
			wait_idle();
			case (phase)
				0: cfg_write(5'd0);
				1: cfg_write(5'd31);
				2: cfg_write(5'd1);
				default: cfg_write(($urandom_range(99, 0) < 70) ?
					5'($urandom_range(8, 0)) : 5'($urandom_range(31, 0)));
			endcase
			if (phase == 2 || phase == 3) begin
				gap_max = 0;
				stall_pct = 0;
			end else begin
				gap_max = $urandom_range(8, 0);
				stall_pct = $urandom_range(70, 0);
			end
			// long receiver hold-off while bytes keep coming
			if (phase == 3)
				hold_req++;
			phase_start = beats_sent;
			while (beats_sent - phase_start < PhaseBytes) begin
				r = $urandom_range(99, 0);
				if (r < 75) begin
					add_text("$");
					repeat (5) sent_buf.push_back(8'($urandom_range(8'h5A, 8'h41)));
					n = $urandom_range(24, 0);
					repeat (n) begin
						if ($urandom_range(99, 0) < 25)
							b = CHAR_COMMA;
						else if ($urandom_range(99, 0) < 5)
							b = 8'($urandom_range(255, 0));
						else
							b = 8'($urandom_range(8'h7E, 8'h20));
						if (b == CHAR_STAR)
							b = CHAR_COMMA;
						sent_buf.push_back(b);
					end
					add_checksum();
					r = $urandom_range(99, 0);
					if (r < 10)
						sent_buf[sent_buf.size() - 1 - $urandom_range(1, 0)] =
							8'($urandom_range(255, 0));
					else if (r < 18)
						void'(sent_buf.pop_back());
					else if (r < 22)
						sent_buf = sent_buf[0:sent_buf.size() - 3];
					else if (r < 37)
						repeat ($urandom_range(6, 1))
							sent_buf.push_back(($urandom_range(99, 0) < 30) ?
								CHAR_COMMA : 8'($urandom_range(255, 0)));
				end else if (r < 85) begin
					add_text("$");
					n = $urandom_range(40, 20);
					repeat (n)
						sent_buf.push_back(($urandom_range(99, 0) < 80) ?
							CHAR_COMMA : 8'($urandom_range(8'h5A, 8'h41)));
					add_checksum();
				end else if (r < 92) begin
					add_text("$GP");
					repeat ($urandom_range(12, 0))
						sent_buf.push_back(($urandom_range(99, 0) < 30) ?
							CHAR_COMMA : 8'($urandom_range(8'h39, 8'h30)));
				end else begin
					repeat ($urandom_range(20, 1))
						sent_buf.push_back(8'($urandom_range(255, 0)));
				end
				send_from(0);
			end
			phase++;
		end
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_field();
		test_checksum_cases();
		test_field_select();
		test_comma_saturation();
		test_long_field();
		test_random();
		repeat (SettleCyc) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
